@@ rtl/sxdf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sxdf_pkg: shared types and constants for the S-expression stream deframer
// Token kinds, error codes, decoder phases and the item and result records.
// ----------------------------------------------------------------------------
package sxdf_pkg;

   localparam int unsigned MAX_PENDING_DEF = 1024;

   localparam int unsigned LIMIT_W = 34;
   localparam int unsigned SIZE_W  = 35;

   localparam logic [7:0]         PAIR_MARK   = 8'hFF;
   localparam logic [7:0]         NIL_MARK    = 8'h80;
   localparam logic [7:0]         SMALL_MAX   = 8'h7F;
   localparam logic [SIZE_W-1:0]  SIZE_CAP    = 35'h4_0000_0000;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 34'h3_FFFF_FFFF;

   typedef enum logic [2:0] {
      KIND_PAIR    = 3'd0,
      KIND_NIL     = 3'd1,
      KIND_SMALL   = 3'd2,
      KIND_HEADER  = 3'd3,
      KIND_PAYLOAD = 3'd4,
      KIND_END     = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_TOO_LARGE = 2'd1,
      ERR_TRUNCATED = 2'd2,
      ERR_OVERFLOW  = 2'd3
   } error_type;

   typedef enum logic [1:0] {
      PH_ITEM    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef struct packed {
      logic       stream_end;
      logic [7:0] in_byte;
   } item_type;

   typedef struct packed {
      kind_type          token_kind;
      logic [7:0]        data_byte;
      logic [SIZE_W-1:0] atom_size;
      logic              atom_done;
      logic              expr_done;
      error_type         error_code;
   } result_type;

endpackage
`default_nettype wire

@@ rtl/sxdf_in_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sxdf_in_stage: input register
// Holds one stream item until the decoder consumes it.
// ----------------------------------------------------------------------------
module sxdf_in_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire sxdf_pkg::item_type req_item,
   output logic                    item_valid,
   input  wire logic               item_take,
   output sxdf_pkg::item_type      item
);

   logic               valid_ff, valid_in;
   sxdf_pkg::item_type item_ff;

   assign req_ready = !valid_ff || item_take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !item_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

@@ rtl/sxdf_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sxdf_core: token decoder
// Classifies one byte, tracks header and payload lengths and the pending
// expression count, and forms the result for that byte.
// ----------------------------------------------------------------------------
module sxdf_core #(
   parameter int unsigned MAX_PENDING = sxdf_pkg::MAX_PENDING_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         fire,
   input  wire sxdf_pkg::item_type           item,
   input  wire logic [sxdf_pkg::LIMIT_W-1:0] limit,
   output sxdf_pkg::result_type              result
);

   localparam int unsigned PW = $clog2(MAX_PENDING + 1);
   localparam int unsigned SW = sxdf_pkg::SIZE_W;
   localparam int unsigned LW = sxdf_pkg::LIMIT_W;

   sxdf_pkg::phase_type phase_ff, phase_in;
   logic [PW-1:0]       pending_ff, pending_in;
   logic [2:0]          header_left_ff, header_left_in;
   logic [SW-1:0]       size_accum_ff, size_accum_in;
   logic [LW-1:0]       payload_left_ff, payload_left_in;

   logic [7:0]    b;
   logic [2:0]    n_ones;
   logic [SW-1:0] size_val;
   logic          hdr_final;
   logic          do_finish;
   logic          do_reinit;

   assign b = item.in_byte;

   // leading ones of a header lead byte (0x81..0xFE)
   always_comb begin
      priority if (!b[6]) begin
         n_ones = 3'd1;
      end else if (!b[5]) begin
         n_ones = 3'd2;
      end else if (!b[4]) begin
         n_ones = 3'd3;
      end else if (!b[3]) begin
         n_ones = 3'd4;
      end else if (!b[2]) begin
         n_ones = 3'd5;
      end else if (!b[1]) begin
         n_ones = 3'd6;
      end else begin
         n_ones = 3'd7;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      pending_in      = pending_ff;
      header_left_in  = header_left_ff;
      size_accum_in   = size_accum_ff;
      payload_left_in = payload_left_ff;
      size_val        = '0;
      hdr_final       = 1'b0;
      do_finish       = 1'b0;
      do_reinit       = 1'b0;

      result            = '0;
      result.data_byte  = b;
      result.token_kind = sxdf_pkg::KIND_HEADER;
      result.error_code = sxdf_pkg::ERR_NONE;

      if (item.stream_end) begin
         result.token_kind = sxdf_pkg::KIND_END;
         result.data_byte  = '0;
         if (!(phase_ff == sxdf_pkg::PH_ITEM && pending_ff == PW'(1))) begin
            result.error_code = sxdf_pkg::ERR_TRUNCATED;
         end
         do_reinit = 1'b1;
      end else begin
         unique case (phase_ff)
            sxdf_pkg::PH_HEADER: begin
               result.token_kind = sxdf_pkg::KIND_HEADER;
               // saturate once the shifted size would reach the cap
               if (size_accum_ff[SW-1:SW-9] != '0) begin
                  size_val = sxdf_pkg::SIZE_CAP;
               end else begin
                  size_val = {1'b0, size_accum_ff[SW-10:0], b};
               end
               size_accum_in = size_val;
               if (header_left_ff != 3'd0) begin
                  header_left_in = header_left_ff - 3'd1;
               end
               hdr_final = (header_left_ff <= 3'd1);
            end
            sxdf_pkg::PH_PAYLOAD: begin
               result.token_kind = sxdf_pkg::KIND_PAYLOAD;
               if (payload_left_ff != '0) begin
                  payload_left_in = payload_left_ff - LW'(1);
               end
               if (payload_left_ff <= LW'(1)) begin
                  phase_in         = sxdf_pkg::PH_ITEM;
                  result.atom_done = 1'b1;
                  do_finish        = 1'b1;
               end
            end
            default: begin
               if (b == sxdf_pkg::PAIR_MARK) begin
                  result.token_kind = sxdf_pkg::KIND_PAIR;
                  if (pending_ff >= PW'(MAX_PENDING)) begin
                     result.error_code = sxdf_pkg::ERR_OVERFLOW;
                     do_reinit         = 1'b1;
                  end else begin
                     pending_in = pending_ff + PW'(1);
                  end
               end else if (b == sxdf_pkg::NIL_MARK || b <= sxdf_pkg::SMALL_MAX) begin
                  result.token_kind = (b == sxdf_pkg::NIL_MARK) ? sxdf_pkg::KIND_NIL
                                                                : sxdf_pkg::KIND_SMALL;
                  result.atom_done  = 1'b1;
                  do_finish         = 1'b1;
               end else begin
                  result.token_kind = sxdf_pkg::KIND_HEADER;
                  size_val          = {{(SW-8){1'b0}}, b & (8'hFF >> n_ones)};
                  size_accum_in     = size_val;
                  if (n_ones > 3'd1) begin
                     phase_in       = sxdf_pkg::PH_HEADER;
                     header_left_in = n_ones - 3'd1;
                  end else begin
                     hdr_final = 1'b1;
                  end
               end
            end
         endcase
      end

      if (hdr_final) begin
         result.atom_size = size_val;
         if (size_val[SW-1] || size_val > {1'b0, limit}) begin
            result.error_code = sxdf_pkg::ERR_TOO_LARGE;
            do_reinit         = 1'b1;
         end else if (size_val == '0) begin
            phase_in         = sxdf_pkg::PH_ITEM;
            result.atom_done = 1'b1;
            do_finish        = 1'b1;
         end else begin
            phase_in        = sxdf_pkg::PH_PAYLOAD;
            payload_left_in = size_val[LW-1:0];
         end
         size_accum_in = '0;
      end

      if (do_finish) begin
         if (pending_ff == PW'(1)) begin
            result.expr_done = 1'b1;
         end else begin
            pending_in = pending_ff - PW'(1);
         end
      end

      if (do_reinit) begin
         phase_in        = sxdf_pkg::PH_ITEM;
         pending_in      = PW'(1);
         header_left_in  = '0;
         size_accum_in   = '0;
         payload_left_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= sxdf_pkg::PH_ITEM;
         pending_ff      <= PW'(1);
         header_left_ff  <= '0;
         size_accum_ff   <= '0;
         payload_left_ff <= '0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         pending_ff      <= pending_in;
         header_left_ff  <= header_left_in;
         size_accum_ff   <= size_accum_in;
         payload_left_ff <= payload_left_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/sxdf_out_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sxdf_out_stage: result register
// Holds one token result until the consumer takes it.
// ----------------------------------------------------------------------------
module sxdf_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire sxdf_pkg::result_type load_result,
   output logic                      can_load,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sxdf_pkg::result_type      rsp_result
);

   logic                 valid_ff, valid_in;
   sxdf_pkg::result_type result_ff;

   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= load_result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule
`default_nettype wire

@@ rtl/sexp_stream_deframer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sexp_stream_deframer: serialized S-expression tokenizer
// Tags each stream byte with a token kind, decodes atom lengths and flags
// completed expressions and stream errors.
//
//   channel  ports   direction  carries
//   req_     in      to block   one stream byte or end marker per transfer
//   rsp_     out     from block one token result per transfer
//   csr_     in      to block   atom_size_limit write
//
// One result per input transfer; each item passes through the input register
// and then the result register before rsp_valid rises.
// One transfer per cycle sustained while rsp_ready holds high; state updates
// in a single pass between the input register and the result register.
// Synchronous active-high reset; the size limit resets to its maximum.
// A stalled rsp_ready holds the result register and backs up into req_ready.
// ----------------------------------------------------------------------------
module sexp_stream_deframer #(
   parameter int unsigned MAX_PENDING = sxdf_pkg::MAX_PENDING_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [7:0]                   req_in_byte,
   input  wire logic                         req_stream_end,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [2:0]                        rsp_token_kind,
   output logic [7:0]                        rsp_data_byte,
   output logic [sxdf_pkg::SIZE_W-1:0]       rsp_atom_size,
   output logic                              rsp_atom_done,
   output logic                              rsp_expr_done,
   output logic [1:0]                        rsp_error_code,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [sxdf_pkg::LIMIT_W-1:0] csr_atom_size_limit
);

   logic [sxdf_pkg::LIMIT_W-1:0] limit_ff;

   sxdf_pkg::item_type   req_item;
   sxdf_pkg::item_type   item;
   sxdf_pkg::result_type result;
   sxdf_pkg::result_type rsp_result;
   logic                 item_valid;
   logic                 can_load;
   logic                 fire;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= sxdf_pkg::LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_atom_size_limit;
      end
   end

   assign req_item.stream_end = req_stream_end;
   assign req_item.in_byte    = req_in_byte;

   assign fire = item_valid && can_load;

   sxdf_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item_take  (can_load),
      .item       (item)
   );

   sxdf_core #(
      .MAX_PENDING (MAX_PENDING)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .limit  (limit_ff),
      .result (result)
   );

   sxdf_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (fire),
      .load_result (result),
      .can_load    (can_load),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_result  (rsp_result)
   );

   assign rsp_token_kind = rsp_result.token_kind;
   assign rsp_data_byte  = rsp_result.data_byte;
   assign rsp_atom_size  = rsp_result.atom_size;
   assign rsp_atom_done  = rsp_result.atom_done;
   assign rsp_expr_done  = rsp_result.expr_done;
   assign rsp_error_code = rsp_result.error_code;

endmodule
`default_nettype wire

@@ bench/tb_sexp_stream_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sexp_stream_deframer: self-checking bench for the S-expression deframer
// Drives serialized expressions, broken streams and noise through the req
// channel under random idling and back-pressure. It predicts every token
// result in a scoreboard and compares the results field by field. The atom
// size limit is swept between phases.
// ----------------------------------------------------------------------------
module tb_sexp_stream_deframer;
   import sxdf_pkg::*;

   localparam int unsigned MAX_NEST     = MAX_PENDING_DEF;
   localparam int unsigned LONG_HOLD    = 300;
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned CHUNK_ITEMS  = 78;

   // Tracks the decoder state and holds the tokens still owed by the block.
   class token_tracker;
      result_type         expected_tokens[$];
      logic [LIMIT_W-1:0] size_limit;
      int unsigned        pending;
      phase_type          phase;
      int unsigned        header_left;
      logic [SIZE_W-1:0]  size_acc;
      logic [LIMIT_W-1:0] payload_left;
      int unsigned        mismatches;
      int unsigned        kind_seen[6];
      int unsigned        err_seen[4];
      int unsigned        exprs_done;

      function new();
         size_limit = LIMIT_RESET;
         restart();
      endfunction

      function void restart();
         pending      = 1;
         phase        = PH_ITEM;
         header_left  = 0;
         size_acc     = '0;
         payload_left = '0;
      endfunction

      function void set_limit(logic [LIMIT_W-1:0] value);
         size_limit = value;
      endfunction

      function bit close_atom();
         pending--;
         if (pending == 0) begin
            pending = 1;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      // last header byte: the size is known now
      function void size_decoded(inout result_type r);
         r.atom_size = size_acc;
         if (size_acc >= SIZE_CAP || size_acc > {1'b0, size_limit}) begin
            r.error_code = ERR_TOO_LARGE;
            restart();
            return;
         end
         if (size_acc == 0) begin
            phase       = PH_ITEM;
            r.atom_done = 1'b1;
            r.expr_done = close_atom();
         end else begin
            phase        = PH_PAYLOAD;
            payload_left = size_acc[LIMIT_W-1:0];
         end
         size_acc = '0;
      endfunction

      function void note_byte(item_type it);
         result_type  r;
         logic [63:0] grown;
         int unsigned ones;
         r = '0;
         if (it.stream_end) begin
            r.token_kind = KIND_END;
            if (!(phase == PH_ITEM && pending == 1))
               r.error_code = ERR_TRUNCATED;
            restart();
         end else if (phase == PH_HEADER) begin
            r.token_kind = KIND_HEADER;
            r.data_byte  = it.in_byte;
            grown        = ({29'd0, size_acc} << 8) | {56'd0, it.in_byte};
            size_acc     = (grown >= SIZE_CAP) ? SIZE_CAP : grown[SIZE_W-1:0];
            if (header_left > 0)
               header_left--;
            if (header_left == 0)
               size_decoded(r);
         end else if (phase == PH_PAYLOAD) begin
            r.token_kind = KIND_PAYLOAD;
            r.data_byte  = it.in_byte;
            if (payload_left != 0)
               payload_left = payload_left - 1'b1;
            if (payload_left == 0) begin
               phase       = PH_ITEM;
               r.atom_done = 1'b1;
               r.expr_done = close_atom();
            end
         end else begin
            r.data_byte = it.in_byte;
            if (it.in_byte == PAIR_MARK) begin
               r.token_kind = KIND_PAIR;
               if (pending >= MAX_NEST) begin
                  r.error_code = ERR_OVERFLOW;
                  restart();
               end else begin
                  pending++;
               end
            end else if (it.in_byte == NIL_MARK || it.in_byte <= SMALL_MAX) begin
               r.token_kind = (it.in_byte == NIL_MARK) ? KIND_NIL : KIND_SMALL;
               r.atom_done  = 1'b1;
               r.expr_done  = close_atom();
            end else begin
               // leading ones of the first header byte = total header bytes
               ones = 0;
               while (ones < 8 && it.in_byte[7 - ones])
                  ones++;
               r.token_kind = KIND_HEADER;
               size_acc     = SIZE_W'(it.in_byte & (8'hFF >> ones));
               if (ones > 1) begin
                  phase       = PH_HEADER;
                  header_left = ones - 1;
               end else begin
                  size_decoded(r);
               end
            end
         end
         kind_seen[r.token_kind]++;
         err_seen[r.error_code]++;
         if (r.expr_done)
            exprs_done++;
         expected_tokens.insert(expected_tokens.size(), r);
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_token(result_type got);
         result_type want;
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token, expected none, actual kind %0d byte 0x%0h",
                     $time, got.token_kind, got.data_byte);
            mismatches++;
            return;
         end
         want = expected_tokens.pop_front();
         compare_field("token_kind", 64'(want.token_kind), 64'(got.token_kind));
         compare_field("data_byte",  64'(want.data_byte),  64'(got.data_byte));
         compare_field("atom_size",  64'(want.atom_size),  64'(got.atom_size));
         compare_field("atom_done",  64'(want.atom_done),  64'(got.atom_done));
         compare_field("expr_done",  64'(want.expr_done),  64'(got.expr_done));
         compare_field("error_code", 64'(want.error_code), 64'(got.error_code));
      endfunction
   endclass

   logic                 clock;
   logic                 reset               = 1'b1;
   logic                 req_valid           = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_in_byte         = 8'h00;
   logic                 req_stream_end      = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready           = 1'b0;
   logic [2:0]           rsp_token_kind;
   logic [7:0]           rsp_data_byte;
   logic [SIZE_W-1:0]    rsp_atom_size;
   logic                 rsp_atom_done;
   logic                 rsp_expr_done;
   logic [1:0]           rsp_error_code;
   logic                 csr_valid           = 1'b0;
   logic                 csr_ready;
   logic [LIMIT_W-1:0]   csr_atom_size_limit = '0;

   token_tracker         sb = new();
   item_type             byte_stream[$];
   logic [LIMIT_W-1:0]   cur_limit    = LIMIT_RESET;
   bit                   gaps_on      = 1'b1;
   bit                   hold_off_req = 1'b0;
   bit                   gen_abort    = 1'b0;
   int unsigned          quiet_cycles = 0;

   sexp_stream_deframer #(.MAX_PENDING(MAX_NEST)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_in_byte         (req_in_byte),
      .req_stream_end      (req_stream_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_token_kind      (rsp_token_kind),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_atom_size       (rsp_atom_size),
      .rsp_atom_done       (rsp_atom_done),
      .rsp_expr_done       (rsp_expr_done),
      .rsp_error_code      (rsp_error_code),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_atom_size_limit (csr_atom_size_limit)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // transfer monitor: feeds the tracker on every accepted transfer
   always @(posedge clock) begin : monitor
      result_type got;
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.set_limit(csr_atom_size_limit);
         if (req_valid && req_ready)
            sb.note_byte({req_stream_end, req_in_byte});
         if (rsp_valid && rsp_ready) begin
            got.token_kind = kind_type'(rsp_token_kind);
            got.data_byte  = rsp_data_byte;
            got.atom_size  = rsp_atom_size;
            got.atom_done  = rsp_atom_done;
            got.expr_done  = rsp_expr_done;
            got.error_code = error_type'(rsp_error_code);
            sb.check_token(got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog, no transfer for %0d cycles, %0d tokens outstanding",
                  $time, quiet_cycles, sb.expected_tokens.size());
         $display("sexp_stream_deframer test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   function automatic void push_byte(logic [7:0] b);
      byte_stream.insert(byte_stream.size(), {1'b0, b});
   endfunction

   function automatic void push_end();
      byte_stream.insert(byte_stream.size(), {1'b1, 8'($urandom)});
   endfunction

   function automatic void gen_sized_atom();
      int unsigned hdr_len, target;
      logic [7:0]  lead, b;
      logic [63:0] sz;
      hdr_len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 7) : $urandom_range(1, 2);
      lead    = ~(8'hFF >> hdr_len);
      if ($urandom_range(0, 4) != 0) begin
         // small size carried in the last header byte, leading bytes zero
         target = $urandom_range((hdr_len == 1) ? 1 : 0, 12);
         push_byte((hdr_len == 1) ? (lead | 8'(target)) : lead);
         for (int k = 1; k < hdr_len; k++)
            push_byte((k == hdr_len - 1) ? 8'(target) : 8'h00);
         sz = target;
      end else begin
         b = lead | (8'($urandom) & (8'hFF >> (hdr_len + 1)));
         if (b == NIL_MARK)
            b = 8'h81;
         push_byte(b);
         sz = b & (8'hFF >> hdr_len);
         for (int k = 1; k < hdr_len; k++) begin
            b = 8'($urandom);
            push_byte(b);
            sz = (sz << 8) | b;
            if (sz >= SIZE_CAP)
               sz = SIZE_CAP;
         end
      end
      if (sz >= SIZE_CAP || sz > cur_limit) begin
         gen_abort = 1'b1;
      end else if (sz <= 16) begin
         repeat (sz) push_byte(8'($urandom));
      end else begin
         // long payload: send a few bytes, then cut the stream
         repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
         push_end();
         gen_abort = 1'b1;
      end
   endfunction

   function automatic void gen_expr(int unsigned depth);
      if (gen_abort)
         return;
      if (depth < 6 && $urandom_range(0, 99) < 35) begin
         push_byte(PAIR_MARK);
         gen_expr(depth + 1);
         gen_expr(depth + 1);
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2: push_byte(8'($urandom_range(0, 127)));
            3:       push_byte(NIL_MARK);
            default: gen_sized_atom();
         endcase
      end
   endfunction

   // mostly well-formed expressions, some cut short, some raw noise
   function automatic void build_chunk(int unsigned count);
      int unsigned mark, cut, pick;
      while (byte_stream.size() < count) begin
         pick      = $urandom_range(0, 99);
         gen_abort = 1'b0;
         if (pick < 72) begin
            gen_expr(0);
            if (!gen_abort && $urandom_range(0, 9) == 0)
               push_end();
         end else if (pick < 86) begin
            mark = byte_stream.size();
            gen_expr(0);
            if (byte_stream.size() > mark + 1) begin
               cut = $urandom_range(mark + 1, byte_stream.size() - 1);
               while (byte_stream.size() > cut)
                  void'(byte_stream.pop_back());
            end
            push_end();
         end else begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 7) == 0)
                  push_end();
               else
                  push_byte(8'($urandom));
            end
         end
      end
   endfunction

   task automatic offer_item(item_type it);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= it.in_byte;
      req_stream_end <= it.stream_end;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_stream();
      while (byte_stream.size() != 0)
         offer_item(byte_stream.pop_front());
      req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (sb.expected_tokens.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] value);
      csr_valid           <= 1'b1;
      csr_atom_size_limit <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_limit = value;
   endtask

   initial begin : main
      logic [LIMIT_W-1:0] limit_plan[6];
      limit_plan[0] = '0;
      limit_plan[1] = 34'd1;
      limit_plan[2] = 34'd12;
      limit_plan[3] = 34'd5000;
      limit_plan[4] = {2'($urandom_range(0, 3)), 32'($urandom)};
      limit_plan[5] = LIMIT_RESET;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: atom kinds, a pair, headers, size extremes, stream ends
      push_byte(8'h00);
      push_byte(SMALL_MAX);
      push_byte(NIL_MARK);
      push_byte(PAIR_MARK);
      push_byte(8'h01);
      push_byte(NIL_MARK);
      push_byte(8'h81);
      push_byte(8'hAA);
      push_byte(8'hC0);                  // two-byte header of size zero
      push_byte(8'h00);
      push_byte(8'hFE);                  // seven-byte header saturates
      repeat (6) push_byte(8'hFF);
      push_byte(8'hFC);                  // largest size the reset limit allows
      push_byte(8'h03);
      repeat (4) push_byte(8'hFF);
      push_byte(8'h5A);
      push_end();                        // cut inside the payload
      push_end();                        // at rest
      push_byte(PAIR_MARK);
      push_end();                        // inside an open pair
      send_stream();
      wait_idle();

      for (int i = 0; i < 6; i++) begin
         if (i == 5)
            gaps_on = 1'b0;
         write_limit(limit_plan[i]);
         build_chunk(CHUNK_ITEMS);
         if (i == 1)
            hold_off_req = 1'b1;
         send_stream();
         wait_idle();
      end

      $display("tokens: %0d pair, %0d nil, %0d small, %0d header, %0d payload, %0d end",
               sb.kind_seen[KIND_PAIR], sb.kind_seen[KIND_NIL], sb.kind_seen[KIND_SMALL],
               sb.kind_seen[KIND_HEADER], sb.kind_seen[KIND_PAYLOAD], sb.kind_seen[KIND_END]);
      $display("%0d expressions closed; errors: %0d oversize, %0d truncated, %0d overflow",
               sb.exprs_done, sb.err_seen[ERR_TOO_LARGE], sb.err_seen[ERR_TRUNCATED],
               sb.err_seen[ERR_OVERFLOW]);
      if (sb.mismatches == 0 && sb.expected_tokens.size() == 0)
         $display("sexp_stream_deframer test passed");
      else
         $display("sexp_stream_deframer test failed");
      $finish;
   end

endmodule
